>>> hw/rtl/gtpm_pkg.sv
// Shared constants, codes and types of the greedy threshold pair matcher.
`timescale 1ns / 1ps

package gtpm_pkg;

   // Default matrix dimensions.
   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;

   // A run never gives more pairs than this.
   localparam int MAX_RESULTS = 64;

   // Field widths.
   localparam int SIM_W   = 16;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_ROW_COUNT      = 2'd0;
   localparam logic [1:0] REG_COL_COUNT      = 2'd1;
   localparam logic [1:0] REG_PAIR_THRESHOLD = 2'd2;

   localparam logic [COUNT_W-1:0] ROW_COUNT_RESET      = 7'd1;
   localparam logic [COUNT_W-1:0] COL_COUNT_RESET      = 7'd1;
   localparam logic [SIM_W-1:0]   PAIR_THRESHOLD_RESET = 16'd16384;

   // Input word operation codes.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_RUN   = 1'b1;

   // Control from the sequencer to the compare unit.
   typedef struct packed {
      logic clear;
      logic live;
   } best_ctl_type;

endpackage

>>> hw/rtl/gtpm_sim_mem.sv
// Similarity store: one write port and one registered read port.
`timescale 1ns / 1ps

module gtpm_sim_mem #(
   parameter int DEPTH  = gtpm_pkg::DEF_MAX_ROWS * gtpm_pkg::DEF_MAX_COLS,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [gtpm_pkg::SIM_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [gtpm_pkg::SIM_W-1:0] rd_data
);

   logic [gtpm_pkg::SIM_W-1:0] mem_ff [DEPTH];
   logic [gtpm_pkg::SIM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/gtpm_best_unit.sv
// Shared compare unit that keeps the largest live entry seen in a scan.
`timescale 1ns / 1ps

module gtpm_best_unit #(
   parameter int ROW_W = 6,
   parameter int COL_W = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gtpm_pkg::best_ctl_type     ctl,
   input  logic [gtpm_pkg::SIM_W-1:0] cand_sim,
   input  logic [ROW_W-1:0]           cand_row,
   input  logic [COL_W-1:0]           cand_col,
   output logic                       best_have,
   output logic [gtpm_pkg::SIM_W-1:0] best_sim,
   output logic [ROW_W-1:0]           best_row,
   output logic [COL_W-1:0]           best_col
);

   logic                       have_ff;
   logic [gtpm_pkg::SIM_W-1:0] sim_ff;
   logic [ROW_W-1:0]           row_ff;
   logic [COL_W-1:0]           col_ff;
   logic                       take;

   // Strictly greater keeps the first entry on a tie.
   assign take = ctl.live && (!have_ff || (cand_sim > sim_ff));

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         have_ff <= 1'b0;
      end else if (take) begin
         have_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sim_ff <= cand_sim;
         row_ff <= cand_row;
         col_ff <= cand_col;
      end
   end

   assign best_have = have_ff;
   assign best_sim  = sim_ff;
   assign best_row  = row_ff;
   assign best_col  = col_ff;

endmodule

>>> hw/rtl/greedy_threshold_pair_matcher_top.sv
// Top level of the greedy threshold pair matcher: sequencer, registers and ports.
`timescale 1ns / 1ps

// Usage. Each input word carries an operation. A write word stores sim_value at
// (row_index, col_index) of the similarity store and gives no result; writes outside
// MAX_ROWS by MAX_COLS are dropped. Outside a run, write words are taken one per cycle.
// A run word starts a greedy matching over the first row_count rows and col_count
// columns, with counts above the store size saturated to it.
// A run is a series of rounds. Each round sweeps the whole active window through
// the single memory read port, one entry per cycle, and one shared compare unit
// keeps the largest entry whose row and column are still free. With R rows and C
// columns in use, a run of k pairs takes k rounds when it ends at min(R, C) pairs,
// or k + 1 rounds when the threshold ends it. Each result word is held until the
// next pair is found or the run ends, since its last flag is known only then. A
// run that finds no pair gives a single word with pair_valid low and last_pair high.
// req_stall is high from a run word until its last result word is loaded into the
// output register. A stalled result word holds, output stalls lengthen the run, and
// a new word is taken while a finished one still waits. Reset is synchronous and
// restores the registers; the store must be written before it is matched.

module greedy_threshold_pair_matcher_top #(
   parameter int MAX_ROWS = gtpm_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = gtpm_pkg::DEF_MAX_COLS
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input channel.
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_operation,
   input  logic [gtpm_pkg::INDEX_W-1:0]    req_row_index,
   input  logic [gtpm_pkg::INDEX_W-1:0]    req_col_index,
   input  logic [gtpm_pkg::SIM_W-1:0]      req_sim_value,
   // Result channel.
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [gtpm_pkg::INDEX_W-1:0]    rsp_pair_row,
   output logic [gtpm_pkg::INDEX_W-1:0]    rsp_pair_col,
   output logic [gtpm_pkg::SIM_W-1:0]      rsp_pair_sim,
   output logic                            rsp_pair_valid,
   output logic                            rsp_last_pair,
   // Configuration port.
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [gtpm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [gtpm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [gtpm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int NR_W    = $clog2(MAX_ROWS + 1);
   localparam int NC_W    = $clog2(MAX_COLS + 1);
   localparam int FOUND_W = $clog2(gtpm_pkg::MAX_RESULTS + 1);
   localparam int SIM_W   = gtpm_pkg::SIM_W;
   localparam int IDX_W   = gtpm_pkg::INDEX_W;
   localparam int CNT_W   = gtpm_pkg::COUNT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_PUSH,
      ST_FINAL
   } state_type;

   // ---------------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------------
   logic [CNT_W-1:0] row_count_ff;
   logic [CNT_W-1:0] col_count_ff;
   logic [SIM_W-1:0] pair_threshold_ff;
   logic             csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff      <= gtpm_pkg::ROW_COUNT_RESET;
         col_count_ff      <= gtpm_pkg::COL_COUNT_RESET;
         pair_threshold_ff <= gtpm_pkg::PAIR_THRESHOLD_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            gtpm_pkg::REG_ROW_COUNT:      row_count_ff      <= pwdata[CNT_W-1:0];
            gtpm_pkg::REG_COL_COUNT:      col_count_ff      <= pwdata[CNT_W-1:0];
            gtpm_pkg::REG_PAIR_THRESHOLD: pair_threshold_ff <= pwdata[SIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         gtpm_pkg::REG_ROW_COUNT:      prdata = 32'(row_count_ff);
         gtpm_pkg::REG_COL_COUNT:      prdata = 32'(col_count_ff);
         gtpm_pkg::REG_PAIR_THRESHOLD: prdata = 32'(pair_threshold_ff);
         default:                      prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Sequencer registers.
   // ---------------------------------------------------------------------------
   state_type          state_ff, state_in;
   logic [NR_W-1:0]    nr_ff, nr_in;
   logic [NC_W-1:0]    nc_ff, nc_in;
   logic [FOUND_W-1:0] limit_ff, limit_in;
   logic [FOUND_W-1:0] found_ff, found_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [MAX_ROWS-1:0] rows_taken_ff, rows_taken_in;
   logic [MAX_COLS-1:0] cols_taken_ff, cols_taken_in;

   // Tag of the entry whose read data the read register holds, registered alongside it.
   logic               tag_live_ff, tag_live_in;
   logic [ROW_W-1:0]   tag_row_ff, tag_row_in;
   logic [COL_W-1:0]   tag_col_ff, tag_col_in;

   // Pair found in the previous round, held until its last flag is known.
   logic               pend_valid_ff, pend_valid_in;
   logic [ROW_W-1:0]   pend_row_ff, pend_row_in;
   logic [COL_W-1:0]   pend_col_ff, pend_col_in;
   logic [SIM_W-1:0]   pend_sim_ff, pend_sim_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [IDX_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [SIM_W-1:0]   rsp_sim_ff, rsp_sim_in;
   logic               rsp_pv_ff, rsp_pv_in;
   logic               rsp_last_ff, rsp_last_in;

   // Memory and compare unit connections.
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [SIM_W-1:0]   mem_rd_data;
   gtpm_pkg::best_ctl_type best_ctl;
   logic               best_have;
   logic [SIM_W-1:0]   best_sim;
   logic [ROW_W-1:0]   best_row;
   logic [COL_W-1:0]   best_col;

   logic               req_accept;
   logic               out_free;
   logic               accept_pair;
   logic               last_col;
   logic               last_row;
   logic [ROW_W+IDX_W-1:0] pend_row_ext;
   logic [COL_W+IDX_W-1:0] pend_col_ext;
   logic [31:0]        row_sat;
   logic [31:0]        col_sat;
   logic [31:0]        lim_tmp;
   logic [31:0]        wr_addr_wide;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Writes outside the configured store are dropped.
   assign wr_addr_wide = 32'(req_row_index) * 32'(MAX_COLS) + 32'(req_col_index);
   assign mem_wr_en    = req_accept && (req_operation == gtpm_pkg::OP_WRITE)
                         && (32'(req_row_index) < 32'(MAX_ROWS))
                         && (32'(req_col_index) < 32'(MAX_COLS));
   assign mem_wr_addr  = wr_addr_wide[ADDR_W-1:0];
   assign mem_rd_en    = (state_ff == ST_SCAN);
   assign mem_rd_addr  = base_ff + ADDR_W'(col_ff);

   assign best_ctl.clear = (state_ff == ST_ROUND);
   assign best_ctl.live  = tag_live_ff;

   assign accept_pair = best_have && (best_sim >= pair_threshold_ff);
   assign last_col    = (32'(col_ff) + 32'd1) == 32'(nc_ff);
   assign last_row    = (32'(row_ff) + 32'd1) == 32'(nr_ff);

   assign pend_row_ext = {{IDX_W{1'b0}}, pend_row_ff};
   assign pend_col_ext = {{IDX_W{1'b0}}, pend_col_ff};

   // Counts above the store size saturate; the pair limit is the smaller count, capped at MAX_RESULTS.
   always_comb begin
      row_sat = (32'(row_count_ff) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(row_count_ff);
      col_sat = (32'(col_count_ff) > 32'(MAX_COLS)) ? 32'(MAX_COLS) : 32'(col_count_ff);
      lim_tmp = (row_sat < col_sat) ? row_sat : col_sat;
      if (lim_tmp > 32'(gtpm_pkg::MAX_RESULTS)) begin
         lim_tmp = 32'(gtpm_pkg::MAX_RESULTS);
      end
   end

   always_comb begin
      state_in      = state_ff;
      nr_in         = nr_ff;
      nc_in         = nc_ff;
      limit_in      = limit_ff;
      found_in      = found_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      base_in       = base_ff;
      rows_taken_in = rows_taken_ff;
      cols_taken_in = cols_taken_ff;
      tag_live_in   = 1'b0;
      tag_row_in    = row_ff;
      tag_col_in    = col_ff;
      pend_valid_in = pend_valid_ff;
      pend_row_in   = pend_row_ff;
      pend_col_in   = pend_col_ff;
      pend_sim_in   = pend_sim_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_sim_in    = rsp_sim_ff;
      rsp_pv_in     = rsp_pv_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_operation == gtpm_pkg::OP_RUN)) begin
               nr_in         = NR_W'(row_sat);
               nc_in         = NC_W'(col_sat);
               limit_in      = FOUND_W'(lim_tmp);
               found_in      = '0;
               rows_taken_in = '0;
               cols_taken_in = '0;
               pend_valid_in = 1'b0;
               state_in      = (lim_tmp == 32'd0) ? ST_FINAL : ST_ROUND;
            end
         end
         ST_ROUND: begin
            row_in   = '0;
            col_in   = '0;
            base_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // Issue one read; the tag follows the data through the read register.
            tag_live_in = !rows_taken_ff[row_ff] && !cols_taken_ff[col_ff];
            if (last_col) begin
               col_in = '0;
               if (last_row) begin
                  state_in = ST_DRAIN;
               end else begin
                  row_in  = row_ff + ROW_W'(1);
                  base_in = base_ff + ADDR_W'(MAX_COLS);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (accept_pair) begin
               rows_taken_in[best_row] = 1'b1;
               cols_taken_in[best_col] = 1'b1;
               found_in = found_ff + FOUND_W'(1);
               state_in = ST_PUSH;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_PUSH: begin
            // Another pair follows, so the held one is not the last.
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_row_in   = pend_row_ext[IDX_W-1:0];
                  rsp_col_in   = pend_col_ext[IDX_W-1:0];
                  rsp_sim_in   = pend_sim_ff;
                  rsp_pv_in    = 1'b1;
                  rsp_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_row_in   = best_row;
               pend_col_in   = best_col;
               pend_sim_in   = best_sim;
               state_in      = (found_ff == limit_ff) ? ST_FINAL : ST_ROUND;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_pv_in     = pend_valid_ff;
               rsp_row_in    = pend_valid_ff ? pend_row_ext[IDX_W-1:0] : '0;
               rsp_col_in    = pend_valid_ff ? pend_col_ext[IDX_W-1:0] : '0;
               rsp_sim_in    = pend_valid_ff ? pend_sim_ff : '0;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         found_ff      <= '0;
         rows_taken_ff <= '0;
         cols_taken_ff <= '0;
         tag_live_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nr_ff         <= nr_in;
         nc_ff         <= nc_in;
         limit_ff      <= limit_in;
         found_ff      <= found_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         base_ff       <= base_in;
         rows_taken_ff <= rows_taken_in;
         cols_taken_ff <= cols_taken_in;
         tag_live_ff   <= tag_live_in;
         tag_row_ff    <= tag_row_in;
         tag_col_ff    <= tag_col_in;
         pend_valid_ff <= pend_valid_in;
         pend_row_ff   <= pend_row_in;
         pend_col_ff   <= pend_col_in;
         pend_sim_ff   <= pend_sim_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_row_ff    <= rsp_row_in;
         rsp_col_ff    <= rsp_col_in;
         rsp_sim_ff    <= rsp_sim_in;
         rsp_pv_ff     <= rsp_pv_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pair_row   = rsp_row_ff;
   assign rsp_pair_col   = rsp_col_ff;
   assign rsp_pair_sim   = rsp_sim_ff;
   assign rsp_pair_valid = rsp_pv_ff;
   assign rsp_last_pair  = rsp_last_ff;

   // ---------------------------------------------------------------------------
   // Datapath instances.
   // ---------------------------------------------------------------------------
   gtpm_sim_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_sim_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_sim_value),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   gtpm_best_unit #(
      .ROW_W (ROW_W),
      .COL_W (COL_W)
   ) u_best_unit (
      .clock     (clock),
      .reset     (reset),
      .ctl       (best_ctl),
      .cand_sim  (mem_rd_data),
      .cand_row  (tag_row_ff),
      .cand_col  (tag_col_ff),
      .best_have (best_have),
      .best_sim  (best_sim),
      .best_row  (best_row),
      .best_col  (best_col)
   );

   // ---------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------
   // Every pair found so far has marked exactly one row and one column.
   a_rows_match_found: assert property (@(posedge clock) disable iff (reset)
      $countones(rows_taken_ff) == 32'(found_ff))
      else $error("taken rows differ from pair count");

   a_cols_match_found: assert property (@(posedge clock) disable iff (reset)
      $countones(cols_taken_ff) == 32'(found_ff))
      else $error("taken columns differ from pair count");

   // No round is scanned once the pair limit is reached.
   a_scan_below_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (found_ff < limit_ff))
      else $error("scan past the pair limit");

   // A live candidate never lies on a row or column already taken.
   a_live_is_free: assert property (@(posedge clock) disable iff (reset)
      tag_live_ff |-> (!rows_taken_ff[tag_row_ff] && !cols_taken_ff[tag_col_ff]))
      else $error("candidate on a taken row or column");

   // A word without a pair always closes its run.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_pv_ff) |-> rsp_last_ff)
      else $error("empty result word not marked last");

endmodule
